/* src/xtea_header_lfsr_stream_cipher_top_assert.svh */
// Assertion macros used by the cipher top module.
`ifndef XTEA_HEADER_LFSR_STREAM_CIPHER_TOP_ASSERT_SVH
`define XTEA_HEADER_LFSR_STREAM_CIPHER_TOP_ASSERT_SVH

// Check out of reset only.
`define XHLSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define XHLSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/xhlsc_pkg.sv */
package xhlsc_pkg;

  localparam logic [31:0] DELTA          = 32'h9E37_79B9;
  localparam logic [31:0] KS_SEED_OR     = 32'h0000_0040;
  localparam logic [15:0] FETCH_SEED_OR  = 16'h0020;
  localparam logic [15:0] FETCH_SEL_MASK = 16'h0410;
  localparam logic [15:0] FETCH_SEL_MAIN = 16'h0400;
  localparam logic [31:0] KS_MSB         = 32'h8000_0000;
  localparam logic [6:0]  RCOUNT_RESET   = 7'd32;
  localparam logic [6:0]  SEED_ENC_ROUND = 7'd2;
  localparam logic [6:0]  SEED_DEC_BACK  = 7'd4;

  typedef enum logic [1:0] {
    CMD_ENC  = 2'd0,
    CMD_DEC  = 2'd1,
    CMD_KEY  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_KEY_LOW    = 3'd0,
    CFG_KEY_HIGH   = 3'd1,
    CFG_ROUNDS     = 3'd2,
    CFG_MAIN_TAPS  = 3'd3,
    CFG_ALT_TAPS   = 3'd4,
    CFG_FETCH_TAPS = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Half-round control: subtract when deciphering; use_low picks word 0 as
  // destination together with the low sum bits as key index.
  typedef struct packed {
    logic sub;
    logic use_low;
  } rnd_ctl_t;

endpackage

/* src/xhlsc_if.sv */
interface xhlsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] block_in;
  logic [7:0]  data_byte;
  modport source(output valid, command, block_in, data_byte, input ready);
  modport sink(input valid, command, block_in, data_byte, output ready);
endinterface

interface xhlsc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;
  logic [7:0]  byte_out;
  modport source(output valid, block_out, byte_out, input ready);
  modport sink(input valid, block_out, byte_out, output ready);
endinterface

interface xhlsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  idx;
  logic [63:0] data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

/* src/xhlsc_round.sv */
module xhlsc_round import xhlsc_pkg::*; (
  input  rnd_ctl_t    ctl,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [31:0] sum,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  output logic [31:0] res
);

  logic [1:0]  kidx;
  logic [31:0] kword;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] mixed;
  logic [31:0] term;

  assign kidx = ctl.use_low ? sum[1:0] : sum[12:11];

  always_comb begin
    case (kidx)
      2'd0:    kword = key_low[31:0];
      2'd1:    kword = key_low[63:32];
      2'd2:    kword = key_high[31:0];
      default: kword = key_high[63:32];
    endcase
  end

  assign src   = ctl.use_low ? w1 : w0;
  assign dst   = ctl.use_low ? w0 : w1;
  assign mixed = ((src << 4) ^ (src >> 5)) + src;
  assign term  = mixed ^ (sum + kword);
  assign res   = ctl.sub ? (dst - term) : (dst + term);

endmodule

/* src/xtea_header_lfsr_stream_cipher_top.sv */
// Channel  Direction  Payload
// in_ch    sink       command, block_in, data_byte
// out_ch   source     block_out, byte_out
// cfg_ch   sink       idx, data (always ready)
//
// Block commands use one shared half-round unit, two steps per XTEA round;
// keystream and unused commands skip the rounds. Reset (rst_n low,
// synchronous) sets the configuration (rounds 32, rest zero) and clears
// both LFSRs and the sequencer, not the payload. A finished result sits in
// the output register; a stalled output holds the sequencer in its last
// step, and in_ch stays not ready until the output register frees.
`include "xtea_header_lfsr_stream_cipher_top_assert.svh"

module xtea_header_lfsr_stream_cipher_top import xhlsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  xhlsc_in_if.sink     in_ch,
  xhlsc_out_if.source  out_ch,
  xhlsc_cfg_if.sink    cfg_ch
);

  // configuration
  logic [63:0] key_low_r, key_high_r;
  logic [6:0]  rcount_r;
  logic [31:0] main_taps_r, alt_taps_r;
  logic [15:0] fetch_taps_r;

  // control and LFSR state
  state_t      state_r, state_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] ks_r, ks_nxt;
  logic [15:0] fetch_r, fetch_nxt;
  logic        out_valid_r, out_valid_nxt;

  // payload
  cmd_t        cmd_r, cmd_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [31:0] w0_r, w0_nxt, w1_r, w1_nxt, sum_r, sum_nxt;
  logic [63:0] block_out_r, block_out_nxt;
  logic [7:0]  byte_out_r, byte_out_nxt;

  logic        in_xfer, cfg_xfer, fin_go, is_dec, last_rnd, seed_en;
  rnd_ctl_t    ctl;
  logic [31:0] rnd_res;
  logic [31:0] taps, ks_step;
  logic [15:0] fetch_step;
  logic [7:0]  b0, b1, b2, b3, kbyte;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign fin_go   = !out_valid_r || out_ch.ready;
  assign is_dec   = (cmd_r == CMD_DEC);
  assign last_rnd = (rnd_r == 7'(rcount_r - 7'd1));

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.block_out = block_out_r;
  assign out_ch.byte_out  = byte_out_r;

  assign ctl.sub     = is_dec;
  assign ctl.use_low = !phase_r ^ is_dec;

  xhlsc_round u_round (
    .ctl      (ctl),
    .key_low  (key_low_r),
    .key_high (key_high_r),
    .sum      (sum_r),
    .w0       (w0_r),
    .w1       (w1_r),
    .res      (rnd_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_ch.command == CMD_ENC || in_ch.command == CMD_DEC) && rcount_r != 7'd0) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_RUN: begin
        if (phase_r && last_rnd) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    seed_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_RUN: begin
        if (phase_r) begin
          seed_en = is_dec ?
            (rcount_r >= SEED_DEC_BACK && rnd_r == 7'(rcount_r - SEED_DEC_BACK)) :
            (rnd_r == SEED_ENC_ROUND);
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // keystream step
  always_comb begin
    taps = ((fetch_r & FETCH_SEL_MASK) == FETCH_SEL_MAIN) ? main_taps_r : alt_taps_r;
    if (ks_r[0]) begin
      ks_step = ((ks_r ^ taps) >> 1) | KS_MSB;
    end else begin
      ks_step = ks_r >> 1;
    end
    if (fetch_r[0]) begin
      fetch_step = (fetch_r << 1) ^ fetch_taps_r;
    end else begin
      fetch_step = (fetch_r << 1) | 16'h0001;
    end
    b0 = ks_step[7:0];
    b1 = ks_step[15:8];
    b2 = ks_step[23:16];
    b3 = ks_step[31:24];
    case (fetch_step[2:0])
      3'd0:    kbyte = (b2 >> 3) | (~b0 & 8'hE0);
      3'd1:    kbyte = b1 ^ b3;
      3'd2:    kbyte = (~b0) ^ (b1 + 8'h15);
      3'd3:    kbyte = b1 + b2 + 8'h40;
      3'd4:    kbyte = (b0 << 4) | (b3 >> 4);
      3'd5:    kbyte = b3 + ((~b2) ^ 8'hA6);
      3'd6:    kbyte = (~b0) ^ (b2 + 8'h81);
      default: kbyte = b1 + (~b3) + 8'd5;
    endcase
  end

  // datapath
  always_comb begin
    rnd_nxt       = rnd_r;
    phase_nxt     = phase_r;
    ks_nxt        = ks_r;
    fetch_nxt     = fetch_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_nxt       = cmd_r;
    data_nxt      = data_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    sum_nxt       = sum_r;
    block_out_nxt = block_out_r;
    byte_out_nxt  = byte_out_r;

    if (state_r == ST_IDLE && in_xfer) begin
      cmd_nxt   = cmd_t'(in_ch.command);
      data_nxt  = in_ch.data_byte;
      w0_nxt    = in_ch.block_in[31:0];
      w1_nxt    = in_ch.block_in[63:32];
      sum_nxt   = (in_ch.command == CMD_DEC) ? DELTA * 32'(rcount_r) : 32'd0;
      rnd_nxt   = 7'd0;
      phase_nxt = 1'b0;
    end

    if (state_r == ST_RUN) begin
      if (ctl.use_low) begin
        w0_nxt = rnd_res;
      end else begin
        w1_nxt = rnd_res;
      end
      if (!phase_r) begin
        sum_nxt = is_dec ? (sum_r - DELTA) : (sum_r + DELTA);
      end else begin
        rnd_nxt = 7'(rnd_r + 7'd1);
      end
      phase_nxt = !phase_r;
      if (seed_en) begin
        ks_nxt    = (w0_nxt ^ w1_nxt) | KS_SEED_OR;
        fetch_nxt = w0_nxt[20:5] | FETCH_SEED_OR;
      end
    end

    if (state_r == ST_FINISH && fin_go) begin
      out_valid_nxt = 1'b1;
      block_out_nxt = 64'd0;
      byte_out_nxt  = 8'd0;
      case (cmd_r) inside
        CMD_ENC, CMD_DEC: block_out_nxt = {w1_r, w0_r};
        CMD_KEY: begin
          byte_out_nxt = data_r ^ kbyte;
          ks_nxt       = ks_step;
          fetch_nxt    = fetch_step;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= 64'd0;
      key_high_r   <= 64'd0;
      rcount_r     <= RCOUNT_RESET;
      main_taps_r  <= 32'd0;
      alt_taps_r   <= 32'd0;
      fetch_taps_r <= 16'd0;
      state_r      <= ST_IDLE;
      rnd_r        <= 7'd0;
      phase_r      <= 1'b0;
      ks_r         <= 32'd0;
      fetch_r      <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      phase_r     <= phase_nxt;
      ks_r        <= ks_nxt;
      fetch_r     <= fetch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_xfer) begin
        unique case (cfg_ch.idx)
          CFG_KEY_LOW:    key_low_r    <= cfg_ch.data;
          CFG_KEY_HIGH:   key_high_r   <= cfg_ch.data;
          CFG_ROUNDS:     rcount_r     <= cfg_ch.data[6:0];
          CFG_MAIN_TAPS:  main_taps_r  <= cfg_ch.data[31:0];
          CFG_ALT_TAPS:   alt_taps_r   <= cfg_ch.data[31:0];
          CFG_FETCH_TAPS: fetch_taps_r <= cfg_ch.data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    data_r      <= data_nxt;
    w0_r        <= w0_nxt;
    w1_r        <= w1_nxt;
    sum_r       <= sum_nxt;
    block_out_r <= block_out_nxt;
    byte_out_r  <= byte_out_nxt;
  end

  `XHLSC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "not idle after reset")
  `XHLSC_ASSERT(a_accept_busy, in_xfer |=> (state_r != ST_IDLE), "transfer left the sequencer idle")
  `XHLSC_ASSERT(a_round_range, (state_r == ST_RUN) |-> (rnd_r < rcount_r), "round counter overran")
  `XHLSC_ASSERT(a_finish_hold, (state_r == ST_FINISH && !fin_go) |=> (state_r == ST_FINISH), "result dropped on stall")
  `XHLSC_ASSERT(a_ks_quiet, (state_r == ST_IDLE) |=> $stable(ks_r), "keystream moved while idle")

endmodule

/* tb/xtea_header_lfsr_stream_cipher_top_test.sv */
module xtea_header_lfsr_stream_cipher_top_test;
  import xhlsc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 2 * 64 + 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 110;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [63:0] blk;
    logic [7:0]  kbyte;
  } cipher_result_t;

  class xtea_keystream_checker;
    logic [63:0] key_lo, key_hi;
    logic [6:0]  rounds;
    logic [31:0] main_mask, alt_mask;
    logic [15:0] fetch_mask;
    logic [31:0] ks_reg;
    logic [15:0] fetch_reg;
    cipher_result_t due_results[$];
    int mismatches, checked;
    int n_enc, n_dec, n_key, n_none;

    function new();
      key_lo = '0;
      key_hi = '0;
      rounds = RCOUNT_RESET;
      main_mask = '0;
      alt_mask = '0;
      fetch_mask = '0;
      ks_reg = '0;
      fetch_reg = '0;
      mismatches = 0;
      checked = 0;
      n_enc = 0;
      n_dec = 0;
      n_key = 0;
      n_none = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [63:0] v);
      case (idx)
        CFG_KEY_LOW:    key_lo = v;
        CFG_KEY_HIGH:   key_hi = v;
        CFG_ROUNDS:     rounds = v[6:0];
        CFG_MAIN_TAPS:  main_mask = v[31:0];
        CFG_ALT_TAPS:   alt_mask = v[31:0];
        CFG_FETCH_TAPS: fetch_mask = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] key_word(logic [1:0] sel);
      case (sel)
        2'd0:    return key_lo[31:0];
        2'd1:    return key_lo[63:32];
        2'd2:    return key_hi[31:0];
        default: return key_hi[63:32];
      endcase
    endfunction

    function logic [31:0] mix(logic [31:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
    endfunction

    function void reseed(logic [31:0] w0, logic [31:0] w1);
      ks_reg = (w0 ^ w1) | KS_SEED_OR;
      fetch_reg = w0[20:5] | FETCH_SEED_OR;
    endfunction

    function logic [63:0] xtea_block(logic [63:0] blk, bit decipher);
      logic [31:0] w0, w1, sum;
      int n, i;
      w0 = blk[31:0];
      w1 = blk[63:32];
      n = rounds;
      if (!decipher) begin
        sum = '0;
        for (i = 0; i < n; i++) begin
          w0 += mix(w1) ^ (sum + key_word(sum[1:0]));
          sum += DELTA;
          w1 += mix(w0) ^ (sum + key_word(sum[12:11]));
          if (i == SEED_ENC_ROUND) reseed(w0, w1);
        end
      end else begin
        sum = DELTA * {25'd0, rounds};
        for (i = 0; i < n; i++) begin
          w1 -= mix(w0) ^ (sum + key_word(sum[12:11]));
          sum -= DELTA;
          w0 -= mix(w1) ^ (sum + key_word(sum[1:0]));
          // seed three rounds before the end, mirroring the encipher side
          if (n >= SEED_DEC_BACK && i == n - SEED_DEC_BACK) reseed(w0, w1);
        end
      end
      return {w1, w0};
    endfunction

    function logic [7:0] next_keystream_byte();
      logic [31:0] taps, r;
      logic [7:0]  b0, b1, b2, b3, v;
      taps = ((fetch_reg & FETCH_SEL_MASK) == FETCH_SEL_MAIN) ? main_mask : alt_mask;
      r = ks_reg;
      if (r[0]) r = ((r ^ taps) >> 1) | KS_MSB;
      else r = r >> 1;
      ks_reg = r;
      if (fetch_reg[0]) fetch_reg = (fetch_reg << 1) ^ fetch_mask;
      else fetch_reg = (fetch_reg << 1) | 16'd1;
      b0 = r[7:0];
      b1 = r[15:8];
      b2 = r[23:16];
      b3 = r[31:24];
      case (fetch_reg[2:0])
        3'd0:    v = (b2 >> 3) | (~b0 & 8'hE0);
        3'd1:    v = b1 ^ b3;
        3'd2:    v = (~b0) ^ (b1 + 8'h15);
        3'd3:    v = b1 + b2 + 8'h40;
        3'd4:    v = (b0 << 4) | (b3 >> 4);
        3'd5:    v = b3 + ((~b2) ^ 8'hA6);
        3'd6:    v = (~b0) ^ (b2 + 8'h81);
        default: v = b1 + (~b3) + 8'd5;
      endcase
      return v;
    endfunction

    function void note_request(cmd_t c, logic [63:0] blk, logic [7:0] db);
      cipher_result_t r;
      r = '0;
      case (c)
        CMD_ENC: begin
          r.blk = xtea_block(blk, 1'b0);
          n_enc++;
        end
        CMD_DEC: begin
          r.blk = xtea_block(blk, 1'b1);
          n_dec++;
        end
        CMD_KEY: begin
          r.kbyte = db ^ next_keystream_byte();
          n_key++;
        end
        default: n_none++;
      endcase
      due_results.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_response(logic [63:0] blk, logic [7:0] kbyte);
      cipher_result_t r;
      checked++;
      if (due_results.size() == 0) begin
        flag("unexpected transfer (block_out)", '0, blk);
        return;
      end
      r = due_results.pop_front();
      if (blk !== r.blk) flag("block_out", r.blk, blk);
      if (kbyte !== r.kbyte) flag("byte_out", {56'd0, r.kbyte}, {56'd0, kbyte});
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  xhlsc_in_if  in_ch();
  xhlsc_out_if out_ch();
  xhlsc_cfg_if cfg_ch();

  xtea_header_lfsr_stream_cipher_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  xtea_keystream_checker chk;
  bit src_gaps;
  bit sink_stalls;
  bit hold_req;
  int items_sent;
  int settings_used;
  int quiet_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(cmd_t c, logic [63:0] blk, logic [7:0] db);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.block_in  <= blk;
    in_ch.data_byte <= db;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chk.note_request(c, blk, db);
    items_sent++;
  endtask

  // header block followed by its keystream bytes, now and then a stray item
  task automatic send_message();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      send_item(cmd_t'($urandom_range(0, 3)), rand64(), 8'($urandom));
    end else begin
      send_item(($urandom_range(0, 2) != 0) ? CMD_ENC : CMD_DEC, rand64(), 8'($urandom));
      n = $urandom_range(1, 16);
      repeat (n) send_item(CMD_KEY, rand64(), 8'($urandom));
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    chk.write_reg(idx, v);
  endtask

  task automatic configure(logic [63:0] kl, logic [63:0] kh, logic [6:0] rc,
                           logic [31:0] mt, logic [31:0] at, logic [15:0] ft);
    write_reg(CFG_KEY_LOW, kl);
    write_reg(CFG_KEY_HIGH, kh);
    write_reg(CFG_ROUNDS, {57'd0, rc});
    write_reg(CFG_MAIN_TAPS, {32'd0, mt});
    write_reg(CFG_ALT_TAPS, {32'd0, at});
    write_reg(CFG_FETCH_TAPS, {48'd0, ft});
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // receiver: runs of ready, random stalls, and one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      chk.check_response(out_ch.block_out, out_ch.byte_out);
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("No transfer for %0d cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int p;
    int target;
    logic [6:0] rc;
    chk = new();
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_NONE;
    in_ch.block_in = '0;
    in_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = CFG_KEY_LOW;
    cfg_ch.data = '0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    settings_used = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: keystream register starts at zero, then the encipher reseeds it
    send_item(CMD_KEY, '0, 8'h00);
    send_item(CMD_KEY, rand64(), 8'hFF);
    send_item(CMD_NONE, '1, 8'hFF);
    send_item(CMD_ENC, '0, 8'h00);
    send_item(CMD_KEY, '0, 8'($urandom));
    drain_results();

    // zero rounds: block passes straight through
    configure(rand64(), rand64(), 7'd0, $urandom, $urandom, 16'($urandom));
    send_item(CMD_ENC, rand64(), 8'h00);
    send_item(CMD_DEC, rand64(), 8'h00);
    send_item(CMD_KEY, rand64(), 8'h5A);
    drain_results();

    // too few rounds to reach the seed point on encipher
    configure(rand64(), rand64(), 7'd2, $urandom, $urandom, 16'($urandom));
    send_item(CMD_ENC, rand64(), 8'h00);
    send_item(CMD_KEY, rand64(), 8'($urandom));
    drain_results();

    // three rounds: decipher skips the seed, encipher reaches it
    configure(rand64(), rand64(), 7'd3, $urandom, $urandom, 16'($urandom));
    send_item(CMD_DEC, rand64(), 8'h00);
    send_item(CMD_KEY, rand64(), 8'($urandom));
    send_item(CMD_ENC, rand64(), 8'h00);
    send_item(CMD_KEY, rand64(), 8'($urandom));
    drain_results();

    configure(rand64(), rand64(), 7'd4, $urandom, $urandom, 16'($urandom));
    send_item(CMD_DEC, '1, 8'h00);
    send_item(CMD_KEY, '1, 8'hFF);
    send_item(CMD_KEY, '0, 8'h00);
    drain_results();

    configure('1, '1, 7'd64, '1, '1, '1);
    send_item(CMD_ENC, '1, 8'hFF);
    send_item(CMD_DEC, '1, 8'h00);
    repeat (3) send_item(CMD_KEY, rand64(), 8'($urandom));
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      src_gaps = (p != PHASES - 1) && (p != 2);
      sink_stalls = (p != PHASES - 1) && (p != 5);
      case (p)
        1: rc = 7'd64;
        2: rc = 7'd4;
        default: rc = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 4))
                                                   : 7'($urandom_range(4, 64));
      endcase
      configure((p == 4) ? 64'd0 : rand64(), (p == 4) ? '1 : rand64(), rc,
                (p == 6) ? 32'd0 : $urandom, (p == 6) ? '1 : $urandom,
                (p == 6) ? 16'd0 : 16'($urandom));
      // hold the output off and keep offering until the input backs up
      if (p == 3) hold_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_message();
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d items over %0d register settings: %0d enciphers, %0d deciphers,",
             items_sent, settings_used, chk.n_enc, chk.n_dec);
    $display("%0d keystream bytes, %0d unused commands; %0d results checked, %0d mismatches",
             chk.n_key, chk.n_none, chk.checked, chk.mismatches);
    if (chk.mismatches == 0 && chk.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
